/* hw/rtl/rtqs_pkg.sv */
// Shared types and constants for the RSS Toeplitz queue selector.
// Holds the hash key, register indexes, action codes and the per-word hash function.
// Depends on nothing.
package rtqs_pkg;

    // Tuple layout: nine 32-bit words, word 0 hashed first.
    localparam int unsigned TUPLE_WORDS = 9;
    localparam int unsigned KEY_BITS    = 320;

    // Queue selection constants.
    localparam int unsigned MAX_QUEUES = 16;
    localparam logic [3:0]  QUEUE_MASK = 4'(MAX_QUEUES - 1);
    localparam logic [31:0] MARK_BASE  = 32'h7cafe800;
    localparam logic [15:0] FRAG_MASK  = 16'h3fff;

    // Header codes.
    localparam logic [3:0] IP_V4     = 4'd4;
    localparam logic [3:0] IP_V6     = 4'd6;
    localparam logic [7:0] PROTO_TCP = 8'd6;
    localparam logic [7:0] PROTO_UDP = 8'd17;

    // Result actions.
    localparam logic [1:0] ACT_PASS    = 2'd0;
    localparam logic [1:0] ACT_PIPE    = 2'd1;
    localparam logic [1:0] ACT_RECLASS = 2'd2;

    // Register indexes (byte address divided by eight).
    localparam logic [1:0] REG_ENABLE = 2'd0;
    localparam logic [1:0] REG_QCOUNT = 2'd1;
    localparam logic [1:0] REG_QTABLE = 2'd2;

    // The forty key bytes read as ten little-endian words, word 0 at the top.
    localparam logic [KEY_BITS-1:0] TPL_KEY = {
        32'h2cc681d1, 32'h5bdbf4f7, 32'hfca28319, 32'hdb1a3e94, 32'h6b9e38d9,
        32'h2c9c03d1, 32'had9944a7, 32'hd9563d59, 32'h063c25f3, 32'hfc1fdc2a
    };

    typedef logic [TUPLE_WORDS-1:0][31:0] tuple_t;

    // Sideband that travels with each request through the pipeline.
    typedef struct packed {
        logic [1:0] action;
    } meta_t;

    // Toeplitz contribution of tuple word j: each set bit folds in a 32-bit key window.
    function automatic logic [31:0] tpl_word_hash(input logic [31:0] w, input int unsigned j);
        logic [31:0] h;
        h = '0;
        for (int unsigned i = 0; i < 32; i++)
        begin
            if (w[31 - i])
            begin
                h ^= TPL_KEY[KEY_BITS - 1 - 32 * j - i -: 32];
            end
        end
        return h;
    endfunction

endpackage

/* hw/rtl/rtqs_hash.sv */
// Two-stage Toeplitz hash: per-word partial hashes, then their XOR.
// Depends on rtqs_pkg for the key, the tuple type and the sideband struct.
module rtqs_hash (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  rtqs_pkg::meta_t  in_meta,
    input  rtqs_pkg::tuple_t in_tuple,
    output logic             out_valid,
    input  logic             out_ready,
    output rtqs_pkg::meta_t  out_meta,
    output logic [31:0]      out_hash
);
    import rtqs_pkg::*;

    tuple_t      part_reg;
    meta_t       meta_a_reg;
    logic        valid_a_reg;
    logic [31:0] hash_reg;
    meta_t       meta_b_reg;
    logic        valid_b_reg;
    logic        ready_a;
    logic        ready_b;
    logic [31:0] hash_next;

    // A stage takes a request when empty or when its own result moves on.
    assign ready_b  = !valid_b_reg || out_ready;
    assign ready_a  = !valid_a_reg || ready_b;
    assign in_ready = ready_a;

    // Stage A: one partial hash per tuple word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
        end
        else if (ready_a)
        begin
            valid_a_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_a && in_valid)
        begin
            meta_a_reg <= in_meta;
            for (int unsigned j = 0; j < TUPLE_WORDS; j++)
            begin
                part_reg[j] <= tpl_word_hash(in_tuple[j], j);
            end
        end
    end

    // Stage B: fold the partial hashes together.
    always_comb
    begin
        hash_next = '0;
        for (int unsigned j = 0; j < TUPLE_WORDS; j++)
        begin
            hash_next ^= part_reg[j];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_b_reg <= 1'b0;
        end
        else if (ready_b)
        begin
            valid_b_reg <= valid_a_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ready_b && valid_a_reg)
        begin
            meta_b_reg <= meta_a_reg;
            hash_reg   <= hash_next;
        end
    end

    assign out_valid = valid_b_reg;
    assign out_meta  = meta_b_reg;
    assign out_hash  = hash_reg;

endmodule

/* hw/rtl/rtqs_mod.sv */
// Pipelined remainder of the 32-bit hash by the queue count, eight bits a stage.
// Depends on rtqs_pkg for the sideband struct.
module rtqs_mod (
    input  logic            clk,
    input  logic            rst_n,
    input  logic [4:0]      divisor,
    input  logic            in_valid,
    output logic            in_ready,
    input  rtqs_pkg::meta_t in_meta,
    input  logic [31:0]     in_hash,
    output logic            out_valid,
    input  logic            out_ready,
    output rtqs_pkg::meta_t out_meta,
    output logic [31:0]     out_hash,
    output logic [4:0]      out_rem
);
    import rtqs_pkg::*;

    localparam int unsigned STAGES    = 4;
    localparam int unsigned STEP_BITS = 32 / STAGES;

    logic        valid_reg [STAGES];
    meta_t       meta_reg  [STAGES];
    logic [31:0] hash_reg  [STAGES];
    logic [4:0]  rem_reg   [STAGES];

    logic        stg_valid [STAGES+1];
    logic        stg_ready [STAGES+1];
    meta_t       stg_meta  [STAGES+1];
    logic [31:0] stg_hash  [STAGES+1];
    logic [4:0]  stg_rem   [STAGES+1];

    // Restoring remainder over a group of hash bits, most significant first.
    function automatic logic [4:0] rem_steps(input logic [4:0] r_in,
                                             input logic [STEP_BITS-1:0] bits,
                                             input logic [4:0] d);
        logic [4:0] r;
        logic [5:0] t;
        r = r_in;
        for (int i = STEP_BITS - 1; i >= 0; i--)
        begin
            t = {r, bits[i]};
            if (t >= {1'b0, d})
            begin
                t = t - {1'b0, d};
            end
            r = t[4:0];
        end
        return r;
    endfunction

    assign stg_valid[0] = in_valid;
    assign stg_meta[0]  = in_meta;
    assign stg_hash[0]  = in_hash;
    assign stg_rem[0]   = '0;
    assign in_ready     = stg_ready[0];
    assign stg_ready[STAGES] = out_ready;

    for (genvar k = 0; k < STAGES; k++)
    begin : g_stage
        // Each stage holds its request until the next one can take it.
        assign stg_ready[k]   = !valid_reg[k] || stg_ready[k+1];
        assign stg_valid[k+1] = valid_reg[k];
        assign stg_meta[k+1]  = meta_reg[k];
        assign stg_hash[k+1]  = hash_reg[k];
        assign stg_rem[k+1]   = rem_reg[k];

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k] <= 1'b0;
            end
            else if (stg_ready[k])
            begin
                valid_reg[k] <= stg_valid[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (stg_ready[k] && stg_valid[k])
            begin
                meta_reg[k] <= stg_meta[k];
                hash_reg[k] <= stg_hash[k];
                rem_reg[k]  <= rem_steps(stg_rem[k],
                                         stg_hash[k][31 - STEP_BITS * k -: STEP_BITS],
                                         divisor);
            end
        end
    end

    assign out_valid = stg_valid[STAGES];
    assign out_meta  = stg_meta[STAGES];
    assign out_hash  = stg_hash[STAGES];
    assign out_rem   = stg_rem[STAGES];

endmodule

/* hw/rtl/rss_toeplitz_queue_select_unit.sv */
// RSS queue selector: Toeplitz hash of the header tuple, reduced by the queue count.
// Pipeline stages from request to result: tuple, two hash, four remainder, output.
// Throughput is one request per cycle while out_ready holds high; the remainder pipeline sets the depth.
// Reset clears all stage valid bits and sets rss_enable 0, queue_count 1, queue_table 0.
// Depends on rtqs_pkg, rtqs_hash and rtqs_mod.
module rss_toeplitz_queue_select_unit (
    input  logic        clk,
    input  logic        rst_n,
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // Header requests
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [3:0]  ip_version,
    input  logic [7:0]  next_proto,
    input  logic [15:0] frag_word,
    input  logic [63:0] src_addr_hi,
    input  logic [63:0] src_addr_lo,
    input  logic [63:0] dst_addr_hi,
    input  logic [63:0] dst_addr_lo,
    input  logic [15:0] src_port,
    input  logic [15:0] dst_port,
    // Results
    output logic        out_valid,
    input  logic        out_ready,
    output logic [1:0]  action,
    output logic [3:0]  queue,
    output logic [31:0] hash_value,
    output logic [31:0] queue_mark
);
    import rtqs_pkg::*;

    logic        rss_enable_reg;
    logic [4:0]  queue_count_reg;
    logic [63:0] queue_table_reg;
    logic        cfg_write;
    logic [4:0]  divisor;

    logic        s1_valid_reg;
    meta_t       s1_meta_reg;
    tuple_t      s1_tuple_reg;
    meta_t       s1_meta_next;
    tuple_t      s1_tuple_next;
    logic        s1_ready;

    logic        hs_valid;
    logic        hs_ready;
    logic        hs_ready_down;
    meta_t       hs_meta;
    logic [31:0] hs_hash;

    logic        md_valid;
    logic        md_ready;
    meta_t       md_meta;
    logic [31:0] md_hash;
    logic [4:0]  md_rem;

    logic        out_valid_reg;
    logic [1:0]  action_reg;
    logic [3:0]  queue_reg;
    logic [31:0] hash_value_reg;
    logic [31:0] queue_mark_reg;
    logic [3:0]  q_index;
    logic [3:0]  q_sel;
    logic [31:0] ports_word;
    logic        l4_proto;

    // Configuration registers.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rss_enable_reg  <= 1'b0;
            queue_count_reg <= 5'd1;
            queue_table_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (paddr[4:3])
                REG_ENABLE: rss_enable_reg  <= pwdata[0];
                REG_QCOUNT: queue_count_reg <= pwdata[4:0];
                REG_QTABLE: queue_table_reg <= pwdata;
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:3])
            REG_ENABLE: prdata = {63'd0, rss_enable_reg};
            REG_QCOUNT: prdata = {59'd0, queue_count_reg};
            REG_QTABLE: prdata = queue_table_reg;
            default:    prdata = '0;
        endcase
    end

    // A zero queue count behaves as one.
    assign divisor = (queue_count_reg == 5'd0) ? 5'd1 : queue_count_reg;

    // Tuple build: IPv4 leaves the trailing words zero, which adds nothing to the hash.
    assign l4_proto   = (next_proto == PROTO_TCP) || (next_proto == PROTO_UDP);
    assign ports_word = {src_port, dst_port};

    always_comb
    begin
        s1_tuple_next = '0;
        if (!rss_enable_reg)
        begin
            s1_meta_next.action = ACT_PASS;
        end
        else if (ip_version == IP_V4)
        begin
            s1_meta_next.action = ACT_RECLASS;
            s1_tuple_next[0] = src_addr_lo[31:0];
            s1_tuple_next[1] = dst_addr_lo[31:0];
            s1_tuple_next[2] = (l4_proto && ((frag_word & FRAG_MASK) == 16'd0)) ?
                               ports_word : 32'd0;
        end
        else if (ip_version == IP_V6)
        begin
            s1_meta_next.action = ACT_RECLASS;
            s1_tuple_next[0] = src_addr_hi[63:32];
            s1_tuple_next[1] = src_addr_hi[31:0];
            s1_tuple_next[2] = src_addr_lo[63:32];
            s1_tuple_next[3] = src_addr_lo[31:0];
            s1_tuple_next[4] = dst_addr_hi[63:32];
            s1_tuple_next[5] = dst_addr_hi[31:0];
            s1_tuple_next[6] = dst_addr_lo[63:32];
            s1_tuple_next[7] = dst_addr_lo[31:0];
            s1_tuple_next[8] = l4_proto ? ports_word : 32'd0;
        end
        else
        begin
            s1_meta_next.action = ACT_PIPE;
        end
    end

    // Tuple stage register.
    assign s1_ready = !s1_valid_reg || hs_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_meta_reg  <= s1_meta_next;
            s1_tuple_reg <= s1_tuple_next;
        end
    end

    // Hash and remainder pipelines.
    rtqs_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s1_valid_reg),
        .in_ready  (hs_ready),
        .in_meta   (s1_meta_reg),
        .in_tuple  (s1_tuple_reg),
        .out_valid (hs_valid),
        .out_ready (hs_ready_down),
        .out_meta  (hs_meta),
        .out_hash  (hs_hash)
    );

    rtqs_mod u_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .divisor   (divisor),
        .in_valid  (hs_valid),
        .in_ready  (hs_ready_down),
        .in_meta   (hs_meta),
        .in_hash   (hs_hash),
        .out_valid (md_valid),
        .out_ready (md_ready),
        .out_meta  (md_meta),
        .out_hash  (md_hash),
        .out_rem   (md_rem)
    );

    // Queue table lookup and output register.
    assign q_index = md_rem[3:0] & QUEUE_MASK;
    assign q_sel   = queue_table_reg[{q_index, 2'b00} +: 4];
    assign md_ready = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (md_ready)
        begin
            out_valid_reg <= md_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (md_ready && md_valid)
        begin
            action_reg <= md_meta.action;
            if (md_meta.action == ACT_RECLASS)
            begin
                queue_reg      <= q_sel;
                hash_value_reg <= md_hash;
                queue_mark_reg <= MARK_BASE + {28'd0, q_sel};
            end
            else
            begin
                queue_reg      <= '0;
                hash_value_reg <= '0;
                queue_mark_reg <= '0;
            end
        end
    end

    assign out_valid  = out_valid_reg;
    assign action     = action_reg;
    assign queue      = queue_reg;
    assign hash_value = hash_value_reg;
    assign queue_mark = queue_mark_reg;

endmodule
